// ===== rtl/core/pip_pkg.sv =====
// Shared types and constants for the point-in-polygon test core.
// No dependencies; imported by the core and its checker.
`timescale 1ns / 1ps

package pip_pkg;

  localparam int MAX_VERTICES = 8;
  localparam int COORD_BITS   = 24;
  localparam int VIDX_BITS    = $clog2(MAX_VERTICES);
  localparam int CNT_BITS     = 4;
  // coordinate differences need one extra bit, products twice that
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS    = 2 * DIFF_BITS;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOADJ,
    S_MUL1,
    S_MUL2,
    S_CMP,
    S_DONE
  } pip_state_t;

endpackage

// ===== rtl/core/point_in_polygon_test_core.sv =====
// Even-odd crossing-number point-in-polygon test over a stored vertex list.
// A query keeps in_stall high until its result word is registered; the single
// shared 25x25 multiplier is visited twice per edge. No new query or vertex
// write is taken while a query is in progress; vertex writes are taken every
// cycle while the core is idle.
// Reset (rst, synchronous): vertex_count clears to 0, no result pending;
// vertex memory is not cleared and must be written before it is used.
`timescale 1ns / 1ps

module point_in_polygon_test_core
  import pip_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [CNT_BITS-1:0]          cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic [2:0]                   vertex_index,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         inside_res
);

  pip_state_t state, state_next;

  logic [CNT_BITS-1:0]          vertex_count;
  logic [CNT_BITS-1:0]          n_clamp;
  logic [CNT_BITS-1:0]          n_used;
  logic [VIDX_BITS-1:0]         idx;
  logic [VIDX_BITS-1:0]         rd_addr;
  logic                         odd_cross;
  logic signed [COORD_BITS-1:0] qx, qy;
  logic signed [COORD_BITS-1:0] prev_x, prev_y;
  logic signed [COORD_BITS-1:0] rd_x, rd_y;
  logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];
  logic signed [DIFF_BITS-1:0]  mul_a, mul_b;
  logic signed [PROD_BITS-1:0]  prod, p_first;
  logic signed [PROD_BITS:0]    cmp_diff;
  logic                         in_accept;
  logic                         last_edge;
  logic                         straddle;
  logic                         dy_pos;
  logic                         left;
  logic                         out_free;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign n_clamp   = (vertex_count > CNT_BITS'(MAX_VERTICES)) ?
                     CNT_BITS'(MAX_VERTICES) : vertex_count;
  assign last_edge = ({1'b0, idx} == (n_used - 1'b1));

  // edge test: vertex i in rd, vertex j in prev
  assign straddle = (rd_y > qy) != (prev_y > qy);
  assign dy_pos   = prev_y > rd_y;
  assign cmp_diff = (PROD_BITS + 1)'(p_first) - (PROD_BITS + 1)'(prod);
  assign left     = dy_pos ? cmp_diff[PROD_BITS] :
                    (!cmp_diff[PROD_BITS] && (cmp_diff != '0));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept && op == OP_QUERY) begin
          state_next = (n_clamp == '0) ? S_DONE : S_LOADJ;
        end
      end
      S_LOADJ: state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_CMP;
      S_CMP:   state_next = last_edge ? S_DONE : S_MUL1;
      S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  // read address and multiplier operands
  always_comb begin
    rd_addr = idx;
    mul_a   = DIFF_BITS'(qx) - DIFF_BITS'(rd_x);
    mul_b   = DIFF_BITS'(prev_y) - DIFF_BITS'(rd_y);
    unique case (state)
      S_IDLE:  rd_addr = VIDX_BITS'(n_clamp - 1'b1);
      S_LOADJ: rd_addr = '0;
      S_CMP:   rd_addr = idx + 1'b1;
      default: rd_addr = idx;
    endcase
    if (state == S_MUL2) begin
      mul_a = DIFF_BITS'(prev_x) - DIFF_BITS'(rd_x);
      mul_b = DIFF_BITS'(qy) - DIFF_BITS'(rd_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // vertex memory
  always_ff @(posedge clk) begin
    if (in_accept && op == OP_WRITE) begin
      mem_x[vertex_index[VIDX_BITS-1:0]] <= coord_x;
      mem_y[vertex_index[VIDX_BITS-1:0]] <= coord_y;
    end
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_accept && op == OP_QUERY) begin
      qx        <= coord_x;
      qy        <= coord_y;
      n_used    <= n_clamp;
      odd_cross <= 1'b0;
    end
    prod <= mul_a * mul_b;
    unique case (state)
      S_LOADJ: begin
        prev_x <= rd_x;
        prev_y <= rd_y;
        idx    <= '0;
      end
      S_MUL2: p_first <= prod;
      S_CMP: begin
        if (straddle && left) begin
          odd_cross <= !odd_cross;
        end
        prev_x <= rd_x;
        prev_y <= rd_y;
        idx    <= idx + 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          inside_res <= odd_cross;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/pip_checker.sv =====
// Port-level checks for point_in_polygon_test_core, bound to every instance of it.
// Depends on pip_pkg for the op codes.
`timescale 1ns / 1ps

module pip_checker
  import pip_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic op,
  input logic out_valid,
  input logic out_stall,
  input logic inside_res
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(inside_res))
    else $error("result word changed while stalled");

  // a query occupies the core
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_QUERY |=> in_stall)
    else $error("core ready right after a query");

  // a vertex write leaves the core ready in the next cycle
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && op == OP_WRITE |=> !in_stall)
    else $error("core busy after a vertex write");

  // a new result only follows a busy period
  a_out_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without a query");

endmodule

bind point_in_polygon_test_core pip_checker u_pip_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .op         (op),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .inside_res (inside_res)
);
